[sv/simu_pkg.sv]
// ----------------------------------------------------------------------------
// simu_pkg
// Shared constants, types and opcodes of the strapdown IMU integrator.
// ----------------------------------------------------------------------------
package simu_pkg;

    localparam int SampleWidthDef = 16;
    localparam int QuatFracDef    = 30;
    localparam int RateScale      = 291924;
    localparam int AddrWidth      = 5;

    localparam logic [15:0] PeriodReset  = 16'd6554;
    localparam logic [19:0] GravityReset = 20'd643026;

    // Register indexes
    localparam logic [2:0] RegPeriod  = 3'd0;
    localparam logic [2:0] RegGravity = 3'd1;
    localparam logic [2:0] RegAbx     = 3'd2;
    localparam logic [2:0] RegAby     = 3'd3;
    localparam logic [2:0] RegAbz     = 3'd4;
    localparam logic [2:0] RegWbx     = 3'd5;
    localparam logic [2:0] RegWby     = 3'd6;
    localparam logic [2:0] RegWbz     = 3'd7;

    // Datapath micro-ops, one per controller state
    typedef enum logic [4:0] {
        OP_NONE  = 5'd0,
        OP_SCALE = 5'd1,   // bias, scale, swap into body frame
        OP_HALF  = 5'd2,   // half-angle step
        OP_DELTA = 5'd3,   // quaternion increment, saturate
        OP_SQSUM = 5'd4,   // sum of squares
        OP_SQRT  = 5'd5,   // one root iteration
        OP_DIV   = 5'd6,   // one divide iteration
        OP_DIVST = 5'd7,   // store quotient, next component
        OP_RMAT  = 5'd8,   // rotation matrix
        OP_ROT   = 5'd9,   // rotate vectors into nav frame
        OP_INTV  = 5'd10,  // velocity and angle integration
        OP_INTP  = 5'd11   // position integration, commit
    } t_op;

    typedef struct packed {
        t_op  op;
        logic start;
    } t_cmd;

    typedef struct packed {
        logic sqrt_done;
        logic div_done;
        logic div_last;
    } t_status;

    function automatic logic signed [63:0] sat32(input logic signed [63:0] x);
        logic signed [63:0] r;
        r = x;
        if (x > 64'sd2147483647) r = 64'sd2147483647;
        else if (x < -64'sd2147483648) r = -64'sd2147483648;
        return r;
    endfunction

    function automatic logic signed [63:0] satsym(input logic signed [63:0] x);
        logic signed [63:0] r;
        r = x;
        if (x > 64'sd2147483647) r = 64'sd2147483647;
        else if (x < -64'sd2147483647) r = -64'sd2147483647;
        return r;
    endfunction

endpackage

[sv/simu_ctrl.sv]
// ----------------------------------------------------------------------------
// simu_ctrl
// Sequencer: steps the datapath through one sample and runs the handshakes.
// ----------------------------------------------------------------------------
module simu_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    output logic                o_valid,
    input  logic                i_stall,
    input  simu_pkg::t_status   i_status,
    output simu_pkg::t_cmd      o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_HALF  = 13'b0000000000010,
        S_DELTA = 13'b0000000000100,
        S_SQSUM = 13'b0000000001000,
        S_SQRT  = 13'b0000000010000,
        S_DIV   = 13'b0000000100000,
        S_DIVST = 13'b0000001000000,
        S_RMAT  = 13'b0000010000000,
        S_ROT   = 13'b0000100000000,
        S_INTV  = 13'b0001000000000,
        S_INTP  = 13'b0010000000000,
        S_OUT   = 13'b0100000000000,
        S_SCALE = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic   w_acc;

    // Output register holds the result; a new beat is taken only when it is empty
    // or being drained, since the result fields are the live state registers.
    assign w_acc   = i_valid && (r_state == S_IDLE) && (!o_valid || !i_stall);
    assign o_stall = !((r_state == S_IDLE) && (!o_valid || !i_stall));

    always_comb begin
        n_state = r_state;
        o_cmd.op = simu_pkg::OP_NONE;
        o_cmd.start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    o_cmd.op = simu_pkg::OP_SCALE;
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin o_cmd.op = simu_pkg::OP_HALF;  n_state = S_HALF; end
            S_HALF:  begin o_cmd.op = simu_pkg::OP_DELTA; n_state = S_DELTA; end
            S_DELTA: begin o_cmd.op = simu_pkg::OP_SQSUM; n_state = S_SQSUM; end
            S_SQSUM: begin
                o_cmd.op = simu_pkg::OP_SQRT;
                o_cmd.start = 1'b1;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.op = simu_pkg::OP_SQRT;
                if (i_status.sqrt_done) begin
                    o_cmd.op = simu_pkg::OP_DIV;
                    o_cmd.start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.op = simu_pkg::OP_DIV;
                if (i_status.div_done) begin
                    o_cmd.op = simu_pkg::OP_DIVST;
                    n_state = S_DIVST;
                end
            end
            S_DIVST: begin
                if (i_status.div_last) begin
                    o_cmd.op = simu_pkg::OP_RMAT;
                    n_state = S_RMAT;
                end else begin
                    o_cmd.op = simu_pkg::OP_DIV;
                    o_cmd.start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_RMAT:  begin o_cmd.op = simu_pkg::OP_ROT;  n_state = S_ROT; end
            S_ROT:   begin o_cmd.op = simu_pkg::OP_INTV; n_state = S_INTV; end
            S_INTV:  begin o_cmd.op = simu_pkg::OP_INTP; n_state = S_INTP; end
            S_INTP:  n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT) o_valid <= 1'b1;
            else if (!i_stall) o_valid <= 1'b0;
        end
    end

endmodule

[sv/simu_dp.sv]
// ----------------------------------------------------------------------------
// simu_dp
// Datapath: sample scaling, quaternion update, bit-serial root and divide,
// rotation and saturating integrators.
// ----------------------------------------------------------------------------
module simu_dp #(
    parameter int SAMPLE_WIDTH   = simu_pkg::SampleWidthDef,
    parameter int QUAT_FRAC_BITS = simu_pkg::QuatFracDef
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  simu_pkg::t_cmd                 i_cmd,
    output simu_pkg::t_status              o_status,
    input  logic        [15:0]             i_period,
    input  logic        [19:0]             i_gravity,
    input  logic signed [15:0]             i_abias [3],
    input  logic signed [15:0]             i_wbias [3],
    input  logic signed [SAMPLE_WIDTH-1:0] i_accel [3],
    input  logic signed [SAMPLE_WIDTH-1:0] i_rate  [3],
    output logic signed [31:0]             o_quat  [4],
    output logic signed [31:0]             o_pos   [3],
    output logic signed [31:0]             o_ang   [3]
);

    localparam int F = QUAT_FRAC_BITS;
    localparam logic signed [63:0] One = 64'sd1 <<< F;

    logic signed [31:0] r_att [4];
    logic signed [31:0] r_vel [3];
    logic signed [31:0] r_pos [3];
    logic signed [31:0] r_ang [3];
    logic signed [31:0] r_ab  [3];
    logic signed [31:0] r_wb  [3];
    logic signed [31:0] r_h   [3];
    logic signed [31:0] r_qn  [4];
    logic signed [31:0] r_n   [4];
    logic signed [31:0] r_rm  [9];
    logic signed [33:0] r_an  [3];
    logic signed [33:0] r_wn  [3];
    logic signed [31:0] r_vnew[3];
    logic        [63:0] r_s;
    logic        [63:0] r_rem;
    logic        [63:0] r_res;
    logic        [63:0] r_bit;
    logic               r_sq_busy;
    logic        [1:0]  r_ci;
    logic        [63:0] r_dnum;
    logic        [63:0] r_dquo;
    logic        [63:0] r_drem;
    logic        [6:0]  r_dcnt;
    logic               r_dneg;

    logic signed [63:0] w_as [3];
    logic signed [63:0] w_ws [3];
    logic signed [63:0] w_d  [4];
    logic signed [63:0] w_ns [4];
    logic signed [63:0] w_sq [4];
    logic signed [63:0] w_x  [6];
    logic        [63:0] w_rb;
    logic        [64:0] w_dtr;
    logic signed [63:0] w_qsel;
    logic signed [63:0] w_quo;

    // Products over full-width values; the controller spends one state per group.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_as[i] = simu_pkg::sat32(
                ((64'(i_accel[i]) + 64'(i_abias[i])) * $signed({44'd0, i_gravity})) >>> 12);
            w_ws[i] = simu_pkg::sat32(
                ((64'(i_rate[i]) + 64'(i_wbias[i])) * 64'sd291924) >>> 4);
        end
        w_d[0] = -(64'(r_h[0]) * 64'(r_att[1]) + 64'(r_h[1]) * 64'(r_att[2])
                 + 64'(r_h[2]) * 64'(r_att[3]));
        w_d[1] = 64'(r_h[0]) * 64'(r_att[0]) - 64'(r_h[1]) * 64'(r_att[3])
               + 64'(r_h[2]) * 64'(r_att[2]);
        w_d[2] = 64'(r_h[0]) * 64'(r_att[3]) + 64'(r_h[1]) * 64'(r_att[0])
               - 64'(r_h[2]) * 64'(r_att[1]);
        w_d[3] = -64'(r_h[0]) * 64'(r_att[2]) + 64'(r_h[1]) * 64'(r_att[1])
               + 64'(r_h[2]) * 64'(r_att[0]);
        for (int i = 0; i < 4; i++) begin
            w_ns[i] = 64'(r_n[i]);
            w_sq[i] = (w_ns[i] * w_ns[i]) >>> F;
        end
        w_x[0] = (w_ns[1] * w_ns[2]) >>> (F - 1);
        w_x[1] = (w_ns[0] * w_ns[3]) >>> (F - 1);
        w_x[2] = (w_ns[1] * w_ns[3]) >>> (F - 1);
        w_x[3] = (w_ns[0] * w_ns[2]) >>> (F - 1);
        w_x[4] = (w_ns[3] * w_ns[2]) >>> (F - 1);
        w_x[5] = (w_ns[0] * w_ns[1]) >>> (F - 1);
        w_rb = r_res + r_bit;
        w_dtr = {r_drem, r_dnum[63]} - {1'b0, r_res};
        w_qsel = 64'(r_qn[r_ci]);
        w_quo = r_dneg ? -$signed(r_dquo) : $signed(r_dquo);
    end

    function automatic logic signed [63:0] clampr(input logic signed [63:0] x);
        logic signed [63:0] r;
        r = x;
        if (x > One) r = One;
        else if (x < -One) r = -One;
        return r;
    endfunction

    assign o_status.sqrt_done = r_sq_busy && (r_bit == 64'd0);
    assign o_status.div_done  = (r_dcnt == 7'd0);
    assign o_status.div_last  = (r_ci == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_att[0] <= 32'(One);
            for (int i = 1; i < 4; i++) r_att[i] <= '0;
            for (int i = 0; i < 3; i++) begin
                r_vel[i] <= '0;
                r_pos[i] <= '0;
                r_ang[i] <= '0;
            end
            r_sq_busy <= 1'b0;
            r_dcnt <= '0;
            r_ci <= '0;
        end else begin
            unique case (i_cmd.op)
                simu_pkg::OP_NONE: ;
                simu_pkg::OP_SCALE: begin
                    r_ab[0] <= 32'(w_as[2]);
                    r_ab[1] <= 32'(w_as[1]);
                    r_ab[2] <= 32'(-w_as[0]);
                    r_wb[0] <= 32'(w_ws[2]);
                    r_wb[1] <= 32'(w_ws[1]);
                    r_wb[2] <= 32'(-w_ws[0]);
                end
                simu_pkg::OP_HALF: begin
                    for (int i = 0; i < 3; i++)
                        r_h[i] <= 32'((64'(r_wb[i]) * $signed({48'd0, i_period})) >>> 17);
                end
                simu_pkg::OP_DELTA: begin
                    for (int i = 0; i < 4; i++)
                        r_qn[i] <= 32'(simu_pkg::satsym(64'(r_att[i]) + (w_d[i] >>> 24)));
                end
                simu_pkg::OP_SQSUM: begin
                    r_s <= 64'(r_qn[0]) * 64'(r_qn[0]) + 64'(r_qn[1]) * 64'(r_qn[1])
                         + 64'(r_qn[2]) * 64'(r_qn[2]) + 64'(r_qn[3]) * 64'(r_qn[3]);
                end
                simu_pkg::OP_SQRT: begin
                    if (i_cmd.start) begin
                        r_rem <= r_s;
                        r_res <= '0;
                        r_bit <= 64'd1 << 62;
                        r_sq_busy <= 1'b1;
                    end else if (r_bit != 64'd0) begin
                        if (r_rem >= w_rb) begin
                            r_rem <= r_rem - w_rb;
                            r_res <= (r_res >> 1) + r_bit;
                        end else begin
                            r_res <= r_res >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                simu_pkg::OP_DIV: begin
                    r_sq_busy <= 1'b0;
                    if (i_cmd.start) begin
                        r_dneg <= w_qsel[63];
                        r_dnum <= (w_qsel[63] ? -w_qsel : w_qsel) <<< F;
                        r_drem <= '0;
                        r_dquo <= '0;
                        r_dcnt <= 7'd64;
                    end else if (r_dcnt != 7'd0) begin
                        if (!w_dtr[64]) begin
                            r_drem <= w_dtr[63:0];
                            r_dquo <= {r_dquo[62:0], 1'b1};
                        end else begin
                            r_drem <= {r_drem[62:0], r_dnum[63]};
                            r_dquo <= {r_dquo[62:0], 1'b0};
                        end
                        r_dnum <= {r_dnum[62:0], 1'b0};
                        r_dcnt <= r_dcnt - 7'd1;
                    end
                end
                simu_pkg::OP_DIVST: begin
                    if (r_res == 64'd0) begin
                        r_n[r_ci] <= (r_ci == 2'd0) ? 32'(One) : '0;
                    end else begin
                        r_n[r_ci] <= 32'(simu_pkg::sat32(w_quo));
                    end
                    r_ci <= r_ci + 2'd1;
                end
                simu_pkg::OP_RMAT: begin
                    r_rm[0] <= 32'(clampr(w_sq[0] + w_sq[1] - w_sq[2] - w_sq[3]));
                    r_rm[1] <= 32'(clampr(w_x[0] - w_x[1]));
                    r_rm[2] <= 32'(clampr(w_x[2] + w_x[3]));
                    r_rm[3] <= 32'(clampr(w_x[0] + w_x[1]));
                    r_rm[4] <= 32'(clampr(w_sq[0] - w_sq[1] + w_sq[2] - w_sq[3]));
                    r_rm[5] <= 32'(clampr(w_x[4] - w_x[5]));
                    r_rm[6] <= 32'(clampr(w_x[2] - w_x[3]));
                    r_rm[7] <= 32'(clampr(w_x[4] + w_x[5]));
                    r_rm[8] <= 32'(clampr(w_sq[0] - w_sq[1] - w_sq[2] + w_sq[3]));
                end
                simu_pkg::OP_ROT: begin
                    for (int i = 0; i < 3; i++) begin
                        r_an[i] <= 34'(((64'(r_rm[3*i]) * 64'(r_ab[0])
                                   + 64'(r_rm[3*i+1]) * 64'(r_ab[1])
                                   + 64'(r_rm[3*i+2]) * 64'(r_ab[2])) >>> F)
                                   - ((i == 2) ? $signed({44'd0, i_gravity}) : 64'sd0));
                        r_wn[i] <= 34'((64'(r_rm[3*i]) * 64'(r_wb[0])
                                   + 64'(r_rm[3*i+1]) * 64'(r_wb[1])
                                   + 64'(r_rm[3*i+2]) * 64'(r_wb[2])) >>> F);
                    end
                end
                simu_pkg::OP_INTV: begin
                    for (int i = 0; i < 3; i++) begin
                        r_vnew[i] <= 32'(simu_pkg::sat32(64'(r_vel[i])
                                   + ((64'(r_an[i]) * $signed({48'd0, i_period})) >>> 16)));
                        r_ang[i] <= 32'(simu_pkg::sat32(64'(r_ang[i])
                                   + ((64'(r_wn[i]) * $signed({48'd0, i_period})) >>> 16)));
                    end
                end
                simu_pkg::OP_INTP: begin
                    for (int i = 0; i < 3; i++) begin
                        r_pos[i] <= 32'(simu_pkg::sat32(64'(r_pos[i])
                                   + (((64'(r_vel[i]) + 64'(r_vnew[i]))
                                   * $signed({48'd0, i_period})) >>> 17)));
                        r_vel[i] <= r_vnew[i];
                    end
                    for (int i = 0; i < 4; i++) r_att[i] <= r_n[i];
                    r_ci <= '0;
                end
                default: ;
            endcase
        end
    end

    assign o_quat = r_att;
    assign o_pos  = r_pos;
    assign o_ang  = r_ang;

endmodule

[sv/simu_regs.sv]
// ----------------------------------------------------------------------------
// simu_regs
// APB configuration register file.
// ----------------------------------------------------------------------------
module simu_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [simu_pkg::AddrWidth-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output logic        [15:0]                o_period,
    output logic        [19:0]                o_gravity,
    output logic signed [15:0]                o_abias [3],
    output logic signed [15:0]                o_wbias [3]
);

    logic [2:0] w_idx;
    assign w_idx  = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_period  <= simu_pkg::PeriodReset;
            o_gravity <= simu_pkg::GravityReset;
            for (int i = 0; i < 3; i++) begin
                o_abias[i] <= '0;
                o_wbias[i] <= '0;
            end
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                simu_pkg::RegPeriod:  o_period   <= pwdata[15:0];
                simu_pkg::RegGravity: o_gravity  <= pwdata[19:0];
                simu_pkg::RegAbx:     o_abias[0] <= pwdata[15:0];
                simu_pkg::RegAby:     o_abias[1] <= pwdata[15:0];
                simu_pkg::RegAbz:     o_abias[2] <= pwdata[15:0];
                simu_pkg::RegWbx:     o_wbias[0] <= pwdata[15:0];
                simu_pkg::RegWby:     o_wbias[1] <= pwdata[15:0];
                simu_pkg::RegWbz:     o_wbias[2] <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            simu_pkg::RegPeriod:  prdata = {16'd0, o_period};
            simu_pkg::RegGravity: prdata = {12'd0, o_gravity};
            simu_pkg::RegAbx:     prdata = 32'(o_abias[0]);
            simu_pkg::RegAby:     prdata = 32'(o_abias[1]);
            simu_pkg::RegAbz:     prdata = 32'(o_abias[2]);
            simu_pkg::RegWbx:     prdata = 32'(o_wbias[0]);
            simu_pkg::RegWby:     prdata = 32'(o_wbias[1]);
            simu_pkg::RegWbz:     prdata = 32'(o_wbias[2]);
            default:              prdata = '0;
        endcase
    end

endmodule

[sv/strapdown_imu_integrator.sv]
// ----------------------------------------------------------------------------
// strapdown_imu_integrator
// From the accepting edge to o_valid: 4 setup steps, 32 root steps and four
// divides of 64 steps each, each ended by a store step, then rotation and
// integration. One beat at a time; no beat is taken while a result waits.
// Synchronous active-low reset: attitude identity, velocity, position, angles
// zero, registers at their defaults. No clearing pass.
// ----------------------------------------------------------------------------
module strapdown_imu_integrator #(
    parameter int SAMPLE_WIDTH   = simu_pkg::SampleWidthDef,
    parameter int QUAT_FRAC_BITS = simu_pkg::QuatFracDef
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [simu_pkg::AddrWidth-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_accel_x,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_accel_y,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_accel_z,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_rate_x,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_rate_y,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_rate_z,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [31:0]                o_quat_w,
    output logic signed [31:0]                o_quat_x,
    output logic signed [31:0]                o_quat_y,
    output logic signed [31:0]                o_quat_z,
    output logic signed [31:0]                o_pos_x,
    output logic signed [31:0]                o_pos_y,
    output logic signed [31:0]                o_pos_z,
    output logic signed [31:0]                o_angle_x,
    output logic signed [31:0]                o_angle_y,
    output logic signed [31:0]                o_angle_z
);

    logic        [15:0] w_period;
    logic        [19:0] w_gravity;
    logic signed [15:0] w_abias [3];
    logic signed [15:0] w_wbias [3];
    logic signed [SAMPLE_WIDTH-1:0] w_accel [3];
    logic signed [SAMPLE_WIDTH-1:0] w_rate  [3];
    logic signed [31:0] w_quat [4];
    logic signed [31:0] w_pos  [3];
    logic signed [31:0] w_ang  [3];
    simu_pkg::t_cmd     w_cmd;
    simu_pkg::t_status  w_status;

    // scaled into the datapath at the accepting edge
    assign w_accel[0] = i_accel_x;
    assign w_accel[1] = i_accel_y;
    assign w_accel[2] = i_accel_z;
    assign w_rate[0]  = i_rate_x;
    assign w_rate[1]  = i_rate_y;
    assign w_rate[2]  = i_rate_z;

    simu_regs u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .o_period(w_period), .o_gravity(w_gravity),
        .o_abias(w_abias), .o_wbias(w_wbias)
    );

    simu_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall,
        .i_status(w_status), .o_cmd(w_cmd)
    );

    simu_dp #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH), .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
    ) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_status(w_status),
        .i_period(w_period), .i_gravity(w_gravity),
        .i_abias(w_abias), .i_wbias(w_wbias),
        .i_accel(w_accel), .i_rate(w_rate),
        .o_quat(w_quat), .o_pos(w_pos), .o_ang(w_ang)
    );

    assign o_quat_w  = w_quat[0];
    assign o_quat_x  = w_quat[1];
    assign o_quat_y  = w_quat[2];
    assign o_quat_z  = w_quat[3];
    assign o_pos_x   = w_pos[0];
    assign o_pos_y   = w_pos[1];
    assign o_pos_z   = w_pos[2];
    assign o_angle_x = w_ang[0];
    assign o_angle_y = w_ang[1];
    assign o_angle_z = w_ang[2];

endmodule

[test/strapdown_imu_integrator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strapdown_imu_integrator_tb
// Drives IMU sample beats through the integrator under random idling on both
// sides. An in-bench navigation model predicts attitude, position and angles
// per beat, and every output beat is checked field by field. The register
// file is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module strapdown_imu_integrator_tb;

    localparam int  QF          = simu_pkg::QuatFracDef;
    localparam int  AW          = simu_pkg::AddrWidth;
    localparam int  DRAIN       = 400;
    localparam longint CYC_LIMIT = 4000000;

    typedef struct packed {
        logic signed [15:0] ax, ay, az, wx, wy, wz;
    } t_imu_sample;

    typedef logic [9:0][31:0] t_nav_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_imu_sample cur = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic signed [31:0] o_quat_w, o_quat_x, o_quat_y, o_quat_z;
    logic signed [31:0] o_pos_x, o_pos_y, o_pos_z;
    logic signed [31:0] o_angle_x, o_angle_y, o_angle_z;

    strapdown_imu_integrator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_accel_x(cur.ax), .i_accel_y(cur.ay), .i_accel_z(cur.az),
        .i_rate_x(cur.wx), .i_rate_y(cur.wy), .i_rate_z(cur.wz),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_quat_w(o_quat_w), .o_quat_x(o_quat_x), .o_quat_y(o_quat_y),
        .o_quat_z(o_quat_z), .o_pos_x(o_pos_x), .o_pos_y(o_pos_y),
        .o_pos_z(o_pos_z), .o_angle_x(o_angle_x), .o_angle_y(o_angle_y),
        .o_angle_z(o_angle_z)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // model registers and state
    longint dt_m, grav_m;
    longint abias_m [3];
    longint wbias_m [3];
    longint att_m [4];
    longint vel_m [3];
    longint pos_m [3];
    longint ang_m [3];

    t_imu_sample sample_q [$];
    t_nav_out    nav_expected [$];
    int     n_err = 0;
    int     n_sent = 0;
    int     n_checked = 0;
    int     n_phases = 0;
    longint cyc = 0;
    bit     took = 1'b0;
    bit     calm = 1'b0;
    int     in_gap = 0;
    int     out_gap = 0;

    function automatic longint clip32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint clipsym(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483647) return -64'sd2147483647;
        return x;
    endfunction

    function automatic longint clip_unit(longint x);
        longint one;
        one = 64'sd1 <<< QF;
        if (x > one) return one;
        if (x < -one) return -one;
        return x;
    endfunction

    function automatic longint mulsh(longint a, longint b, int n);
        return (a * b) >>> n;
    endfunction

    function automatic longint unsigned int_root(longint unsigned x);
        longint unsigned res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > x) bt = bt >> 2;
        while (bt != 0) begin
            if (x >= res + bt) begin
                x = x - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic int gap_len();
        if (calm) return 0;
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
        return $urandom_range(5, 40);
    endfunction

    function automatic string field_name(int i);
        case (i)
            0: return "quat_w";
            1: return "quat_x";
            2: return "quat_y";
            3: return "quat_z";
            4: return "pos_x";
            5: return "pos_y";
            6: return "pos_z";
            7: return "angle_x";
            8: return "angle_y";
            default: return "angle_z";
        endcase
    endfunction

    task automatic nav_reset();
        dt_m = simu_pkg::PeriodReset;
        grav_m = simu_pkg::GravityReset;
        for (int i = 0; i < 3; i++) begin
            abias_m[i] = 0; wbias_m[i] = 0;
            vel_m[i] = 0; pos_m[i] = 0; ang_m[i] = 0;
        end
        att_m[0] = 64'sd1 <<< QF;
        att_m[1] = 0; att_m[2] = 0; att_m[3] = 0;
    endtask

    task automatic nav_advance(input t_imu_sample s, output t_nav_out res);
        longint raw_a [3];
        longint raw_w [3];
        longint sa [3];
        longint sw [3];
        longint ab [3];
        longint wb [3];
        longint h [3];
        longint q [4];
        longint d [4];
        longint qn [4];
        longint n [4];
        longint rm [3][3];
        longint an [3];
        longint wn [3];
        longint vo, vn;
        longint unsigned ssum, r;
        raw_a[0] = s.ax; raw_a[1] = s.ay; raw_a[2] = s.az;
        raw_w[0] = s.wx; raw_w[1] = s.wy; raw_w[2] = s.wz;
        for (int i = 0; i < 3; i++) begin
            sa[i] = clip32(((raw_a[i] + abias_m[i]) * grav_m) >>> 12);
            sw[i] = clip32(((raw_w[i] + wbias_m[i]) * longint'(simu_pkg::RateScale)) >>> 4);
        end
        ab[0] = sa[2]; ab[1] = sa[1]; ab[2] = -sa[0];
        wb[0] = sw[2]; wb[1] = sw[1]; wb[2] = -sw[0];
        for (int i = 0; i < 3; i++) h[i] = (wb[i] * dt_m) >>> 17;
        for (int i = 0; i < 4; i++) q[i] = att_m[i];
        d[0] = -(h[0] * q[1] + h[1] * q[2] + h[2] * q[3]);
        d[1] = h[0] * q[0] - h[1] * q[3] + h[2] * q[2];
        d[2] = h[0] * q[3] + h[1] * q[0] - h[2] * q[1];
        d[3] = -h[0] * q[2] + h[1] * q[1] + h[2] * q[0];
        ssum = 0;
        for (int i = 0; i < 4; i++) begin
            qn[i] = clipsym(q[i] + (d[i] >>> 24));
            ssum = ssum + longint'(qn[i] * qn[i]);
        end
        r = int_root(ssum);
        if (r == 0) begin
            n[0] = 64'sd1 <<< QF; n[1] = 0; n[2] = 0; n[3] = 0;
        end else begin
            for (int i = 0; i < 4; i++) n[i] = clip32((qn[i] <<< QF) / longint'(r));
        end
        rm[0][0] = clip_unit(mulsh(n[0], n[0], QF) + mulsh(n[1], n[1], QF)
                           - mulsh(n[2], n[2], QF) - mulsh(n[3], n[3], QF));
        rm[0][1] = clip_unit(mulsh(n[1], n[2], QF - 1) - mulsh(n[0], n[3], QF - 1));
        rm[0][2] = clip_unit(mulsh(n[1], n[3], QF - 1) + mulsh(n[0], n[2], QF - 1));
        rm[1][0] = clip_unit(mulsh(n[1], n[2], QF - 1) + mulsh(n[0], n[3], QF - 1));
        rm[1][1] = clip_unit(mulsh(n[0], n[0], QF) - mulsh(n[1], n[1], QF)
                           + mulsh(n[2], n[2], QF) - mulsh(n[3], n[3], QF));
        rm[1][2] = clip_unit(mulsh(n[3], n[2], QF - 1) - mulsh(n[0], n[1], QF - 1));
        rm[2][0] = clip_unit(mulsh(n[1], n[3], QF - 1) - mulsh(n[0], n[2], QF - 1));
        rm[2][1] = clip_unit(mulsh(n[3], n[2], QF - 1) + mulsh(n[0], n[1], QF - 1));
        rm[2][2] = clip_unit(mulsh(n[0], n[0], QF) - mulsh(n[1], n[1], QF)
                           - mulsh(n[2], n[2], QF) + mulsh(n[3], n[3], QF));
        for (int i = 0; i < 3; i++) begin
            an[i] = (rm[i][0] * ab[0] + rm[i][1] * ab[1] + rm[i][2] * ab[2]) >>> QF;
            wn[i] = (rm[i][0] * wb[0] + rm[i][1] * wb[1] + rm[i][2] * wb[2]) >>> QF;
        end
        an[2] = an[2] - grav_m;
        for (int i = 0; i < 3; i++) begin
            vo = vel_m[i];
            vn = clip32(vo + ((an[i] * dt_m) >>> 16));
            pos_m[i] = clip32(pos_m[i] + (((vo + vn) * dt_m) >>> 17));
            vel_m[i] = vn;
            ang_m[i] = clip32(ang_m[i] + ((wn[i] * dt_m) >>> 16));
        end
        for (int i = 0; i < 4; i++) att_m[i] = n[i];
        for (int i = 0; i < 4; i++) res[9 - i] = att_m[i][31:0];
        for (int i = 0; i < 3; i++) begin
            res[5 - i] = pos_m[i][31:0];
            res[2 - i] = ang_m[i][31:0];
        end
    endtask

    // res[9] holds quat_w ... res[0] holds angle_z
    always @(posedge i_clk) begin
        t_nav_out pred, got;
        cyc <= cyc + 1;
        if ($urandom_range(0, 299) == 0) calm <= ~calm;
        took = i_rst_n && i_valid && !o_stall;
        if (took) begin
            nav_advance(cur, pred);
            nav_expected.push_back(pred);
            n_sent++;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_quat_w, o_quat_x, o_quat_y, o_quat_z, o_pos_x, o_pos_y, o_pos_z,
                   o_angle_x, o_angle_y, o_angle_z};
            if (nav_expected.size() == 0) begin
                $error("output beat with nothing expected");
                n_err++;
            end else begin
                pred = nav_expected.pop_front();
                for (int i = 0; i < 10; i++) begin
                    if (got[9 - i] !== pred[9 - i]) begin
                        $error("%s: expected %0d, got %0d", field_name(i),
                               $signed(pred[9 - i]), $signed(got[9 - i]));
                        n_err++;
                    end
                end
                n_checked++;
            end
        end
        if (cyc > CYC_LIMIT) begin
            $display("strapdown_imu_integrator_tb: errors");
            $finish;
        end
    end

    // sample driver
    always @(negedge i_clk) begin
        if (!i_valid || took) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                i_valid <= 1'b0;
            end else if (i_rst_n && sample_q.size() > 0) begin
                cur <= sample_q.pop_front();
                i_valid <= 1'b1;
                in_gap <= gap_len();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // output back-pressure
    always @(negedge i_clk) begin
        if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            out_gap <= gap_len();
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= AW'(idx) << 2;
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            simu_pkg::RegPeriod:  dt_m = val[15:0];
            simu_pkg::RegGravity: grav_m = val[19:0];
            simu_pkg::RegAbx, simu_pkg::RegAby, simu_pkg::RegAbz:
                abias_m[idx - simu_pkg::RegAbx] = longint'($signed(val[15:0]));
            default: wbias_m[idx - simu_pkg::RegWbx] = longint'($signed(val[15:0]));
        endcase
    endtask

    task automatic wait_idle();
        while (sample_q.size() > 0 || i_valid || nav_expected.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [15:0] per, input logic [19:0] grav,
                            input logic [15:0] ab, input logic [15:0] wb);
        reg_write(simu_pkg::RegPeriod, {16'd0, per});
        reg_write(simu_pkg::RegGravity, {12'd0, grav});
        reg_write(simu_pkg::RegAbx, {16'd0, ab});
        reg_write(simu_pkg::RegAby, {16'd0, ~ab});
        reg_write(simu_pkg::RegAbz, {16'd0, ab});
        reg_write(simu_pkg::RegWbx, {16'd0, wb});
        reg_write(simu_pkg::RegWby, {16'd0, ~wb});
        reg_write(simu_pkg::RegWbz, {16'd0, wb});
        n_phases++;
    endtask

    task automatic push_random(input int count);
        t_imu_sample s;
        for (int k = 0; k < count; k++) begin
            s = {$urandom, $urandom, $urandom};
            if ($urandom_range(0, 3) == 0) begin
                // gentle motion keeps the attitude from spinning wildly
                s.wx = $signed(16'($urandom_range(0, 255))) - 16'sd128;
                s.wy = $signed(16'($urandom_range(0, 255))) - 16'sd128;
                s.wz = $signed(16'($urandom_range(0, 255))) - 16'sd128;
            end
            sample_q.push_back(s);
        end
    endtask

    initial begin
        t_imu_sample s;
        nav_reset();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero, extremes, single-field extremes, bit patterns
        sample_q.push_back('0);
        sample_q.push_back({6{16'sh7fff}});
        sample_q.push_back({6{16'sh8000}});
        for (int f = 0; f < 6; f++) begin
            s = '0;
            s[16 * f +: 16] = 16'h7fff;
            sample_q.push_back(s);
            s[16 * f +: 16] = 16'h8000;
            sample_q.push_back(s);
        end
        sample_q.push_back({6{16'h5555}});
        sample_q.push_back({6{16'haaaa}});
        sample_q.push_back({16'd4096, 16'd0, 16'd0, 16'd16, 16'hfff0, 16'd0});
        push_random(300);
        wait_idle();

        // extreme step, gravity and biases
        set_regs(16'hffff, 20'hfffff, 16'h7fff, 16'h7fff);
        sample_q.push_back({6{16'sh7fff}});
        sample_q.push_back({6{16'sh8000}});
        push_random(250);
        wait_idle();

        // zero step: attitude only renormalized, nothing moves
        set_regs(16'd0, 20'd643026, 16'h8000, 16'h8000);
        push_random(150);
        wait_idle();

        // smallest step, no gravity, negative x and z biases
        set_regs(16'd1, 20'd0, 16'h8000, 16'h8001);
        push_random(250);
        wait_idle();

        for (int p = 0; p < 3; p++) begin
            set_regs(16'($urandom_range(1, 65535)), 20'($urandom),
                     16'($urandom), 16'($urandom));
            push_random(200);
            wait_idle();
        end

        $display("covered %0d sample beats, %0d checked, over %0d register settings",
                 n_sent, n_checked, n_phases + 1);
        if (n_err == 0) begin
            $display("strapdown_imu_integrator_tb: clean");
        end else begin
            $display("strapdown_imu_integrator_tb: errors");
        end
        $finish;
    end

endmodule
